// File: sv/dqrt_pkg.sv
package dqrt_pkg;

  // Sizes of the slot table and the histogram.
  localparam int unsigned HIST_BUCKETS = 1024;
  localparam int unsigned ID_SLOTS     = 65536;
  localparam int unsigned ID_W         = $clog2(ID_SLOTS);
  localparam int unsigned HIST_AW      = $clog2(HIST_BUCKETS);

  // Busy bits are held as rows of 64 so that the clearing pass is short.
  localparam int unsigned ROW_BITS  = 64;
  localparam int unsigned ROW_W     = $clog2(ROW_BITS);
  localparam int unsigned BUSY_ROWS = ID_SLOTS / ROW_BITS;
  localparam int unsigned ROW_AW    = $clog2(BUSY_ROWS);

  // Clearing pass covers the larger of the busy rows and the histogram.
  localparam int unsigned CLR_N = (BUSY_ROWS > HIST_BUCKETS) ? BUSY_ROWS : HIST_BUCKETS;
  localparam int unsigned CLR_W = $clog2(CLR_N);

  // Field widths of one transfer.
  localparam int unsigned TS_W    = 64;
  localparam int unsigned RCODE_W = 4;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned BIDX_W  = 10;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STS_W   = 3;
  localparam int unsigned BCNT_W  = ID_W + 1;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 656;

  // Microsecond bucketing: rtt / 1000 by reciprocal multiplication.
  localparam longint unsigned NS_PER_US = 1000;
  localparam longint unsigned HIST_NS   = HIST_BUCKETS * NS_PER_US;
  localparam int unsigned     HNS_W     = $clog2(HIST_NS);
  localparam int unsigned     DIV_SH    = HNS_W + 10;
  localparam longint unsigned RECIP     = ((64'd1 << DIV_SH) + NS_PER_US - 1) / NS_PER_US;
  localparam int unsigned     RECIP_W   = DIV_SH - 9;
  localparam int unsigned     PROD_W    = HNS_W + RECIP_W;

  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(12);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_SEND   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BUCKET = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd3;

  // Result status codes.
  localparam logic [STS_W-1:0] STS_SENT    = 3'd0;
  localparam logic [STS_W-1:0] STS_EVICT   = 3'd1;
  localparam logic [STS_W-1:0] STS_MATCH   = 3'd2;
  localparam logic [STS_W-1:0] STS_IGNORED = 3'd3;
  localparam logic [STS_W-1:0] STS_BUCKET  = 3'd4;
  localparam logic [STS_W-1:0] STS_FINISH  = 3'd5;

  // DNS response codes with counters of their own.
  localparam logic [RCODE_W-1:0] RC_OK       = 4'd0;
  localparam logic [RCODE_W-1:0] RC_SRV_FAIL = 4'd2;
  localparam logic [RCODE_W-1:0] RC_NAME_ERR = 4'd3;

  // Statistics counter positions.
  localparam int unsigned STAT_TIMEOUT = 0;
  localparam int unsigned STAT_RESP    = 1;
  localparam int unsigned STAT_SUM     = 2;
  localparam int unsigned STAT_MIN     = 3;
  localparam int unsigned STAT_MAX     = 4;
  localparam int unsigned STAT_NOERR   = 5;
  localparam int unsigned STAT_NXDOM   = 6;
  localparam int unsigned STAT_SRVF    = 7;
  localparam int unsigned STAT_OTHER   = 8;
  localparam int unsigned STAT_N       = 9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic load;
    logic calc;
    logic stat;
    logic hrd;
    logic hwr;
    logic out_ld;
  } dqrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              clr_done;
    logic [KIND_W-1:0] kind;
    logic              hist_hit;
    logic              out_busy;
  } dqrt_sts_t;

endpackage

// File: sv/dqrt_ctrl.sv
module dqrt_ctrl import dqrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dqrt_sts_t  sts_i,
  output dqrt_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CALC,
    S_STAT,
    S_HRD,
    S_HWR,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clr_done) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_READ;
      S_READ:  state_d = S_CALC;
      S_CALC:  state_d = (sts_i.kind == KIND_RESP) ? S_STAT : S_OUT;
      S_STAT:  state_d = sts_i.hist_hit ? S_HRD : S_OUT;
      S_HRD:   state_d = S_HWR;
      S_HWR:   state_d = S_OUT;
      S_OUT:   if (!sts_i.out_busy) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Command decode.
  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.clr     = (state_q == S_CLEAR);
  assign cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.calc    = (state_q == S_CALC);
  assign cmd_o.stat    = (state_q == S_STAT);
  assign cmd_o.hrd     = (state_q == S_HRD);
  assign cmd_o.hwr     = (state_q == S_HWR);
  assign cmd_o.out_ld  = (state_q == S_OUT) && !sts_i.out_busy;

endmodule

// File: sv/dqrt_dp.sv
module dqrt_dp import dqrt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dqrt_cmd_t              cmd_i,
  output dqrt_sts_t              sts_o,
  input  logic [KIND_W-1:0]      in_kind_i,
  input  logic [IN_DATA_W-1:0]   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STS_W-1:0]       out_status_o,
  output logic [OUT_DATA_W-1:0]  out_data_o
);

  // Input fields held for the item at work.
  logic [KIND_W-1:0]  kind_q;
  logic [TS_W-1:0]    ts_q;
  logic [RCODE_W-1:0] rcode_q;
  logic [LEN_W-1:0]   rlen_q;
  logic [BIDX_W-1:0]  bidx_q;
  logic [ID_W-1:0]    id_q;

  logic [ID_W-1:0]    next_id_q;
  logic [BCNT_W-1:0]  busy_cnt_q;
  logic [CLR_W-1:0]   clr_cnt_q;
  logic [63:0]        stat_q [STAT_N];

  logic [STS_W-1:0]   status_q;
  logic [ID_W-1:0]    assigned_q;
  logic [63:0]        value_q;
  logic               matched_q;
  logic [HIST_AW-1:0] bucket_q;

  // Memories.
  logic [TS_W-1:0]     time_mem [ID_SLOTS];
  logic [ROW_BITS-1:0] busy_mem [BUSY_ROWS];
  logic [63:0]         hist_mem [HIST_BUCKETS];

  logic [TS_W-1:0]     time_rd_q;
  logic [ROW_BITS-1:0] busy_rd_q;
  logic [63:0]         hist_rd_q;

  logic                out_valid_q;
  logic [STS_W-1:0]    out_status_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic                slot_busy;
  logic                resp_ok;
  logic [ROW_BITS-1:0] row_new;
  logic                busy_we;
  logic [HIST_AW-1:0]  hist_raddr;
  logic                bidx_ok;
  logic                hist_hit;
  logic [PROD_W-1:0]   prod;

  assign slot_busy = busy_rd_q[id_q[ROW_W-1:0]];
  assign resp_ok   = (rlen_q >= MIN_LEN) && slot_busy;
  assign bidx_ok   = (64'(bidx_q) < 64'(HIST_BUCKETS));
  assign hist_hit  = matched_q && (value_q < HIST_NS);
  assign prod      = PROD_W'(value_q[HNS_W-1:0]) * PROD_W'(RECIP);

  // Busy row with the slot's bit set on a send and cleared on a match.
  always_comb begin
    row_new = busy_rd_q;
    row_new[id_q[ROW_W-1:0]] = (kind_q == KIND_SEND);
  end
  assign busy_we = cmd_i.calc && ((kind_q == KIND_SEND) || ((kind_q == KIND_RESP) && resp_ok));

  assign hist_raddr = cmd_i.hrd ? bucket_q : HIST_AW'(bidx_q);

  // Slot time memory: written on a send, read every cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc && (kind_q == KIND_SEND)) begin
      time_mem[id_q] <= ts_q;
    end
    time_rd_q <= time_mem[id_q];
  end

  // Busy row memory: cleared by the pass after reset, then read-modify-write.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      busy_mem[ROW_AW'(clr_cnt_q)] <= '0;
    end else if (busy_we) begin
      busy_mem[id_q[ID_W-1:ROW_W]] <= row_new;
    end
    busy_rd_q <= busy_mem[id_q[ID_W-1:ROW_W]];
  end

  // Histogram memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      if (32'(clr_cnt_q) < HIST_BUCKETS) begin
        hist_mem[HIST_AW'(clr_cnt_q)] <= '0;
      end
    end else if (cmd_i.hwr) begin
      hist_mem[bucket_q] <= hist_rd_q + 64'd1;
    end
    hist_rd_q <= hist_mem[hist_raddr];
  end

  // Clearing pass counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr && (clr_cnt_q != CLR_W'(CLR_N - 1))) begin
      clr_cnt_q <= clr_cnt_q + CLR_W'(1);
    end
  end

  // Capture of the accepted transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ts_q    <= in_data_i[63:0];
      rcode_q <= in_data_i[83:80];
      rlen_q  <= in_data_i[93:84];
      bidx_q  <= in_data_i[103:94];
      id_q    <= (in_kind_i == KIND_SEND) ? next_id_q : in_data_i[79:64];
    end
  end

  // Per-item result fields and the bucket index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      assigned_q <= (kind_q == KIND_SEND) ? id_q : '0;
      value_q    <= '0;
      matched_q  <= 1'b0;
      unique case (kind_q)
        KIND_SEND:   status_q <= slot_busy ? STS_EVICT : STS_SENT;
        KIND_RESP: begin
          if (resp_ok) begin
            status_q  <= STS_MATCH;
            value_q   <= ts_q - time_rd_q;
            matched_q <= 1'b1;
          end else begin
            status_q  <= STS_IGNORED;
          end
        end
        KIND_BUCKET: begin
          status_q <= STS_BUCKET;
          value_q  <= bidx_ok ? hist_rd_q : '0;
        end
        default:     status_q <= STS_FINISH;
      endcase
    end
    if (cmd_i.stat) begin
      bucket_q <= prod[DIV_SH +: HIST_AW];
    end
  end

  // Control registers: kind, next ID, busy count and statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= KIND_SEND;
      next_id_q  <= '0;
      busy_cnt_q <= '0;
      for (int i = 0; i < STAT_N; i++) begin
        stat_q[i] <= (i == STAT_MIN) ? '1 : '0;
      end
    end else begin
      if (cmd_i.load) begin
        kind_q <= in_kind_i;
      end
      if (cmd_i.calc) begin
        unique case (kind_q)
          KIND_SEND: begin
            next_id_q <= next_id_q + ID_W'(1);
            if (slot_busy) begin
              stat_q[STAT_TIMEOUT] <= stat_q[STAT_TIMEOUT] + 64'd1;
            end else begin
              busy_cnt_q <= busy_cnt_q + BCNT_W'(1);
            end
          end
          KIND_RESP: begin
            if (resp_ok) begin
              busy_cnt_q <= busy_cnt_q - BCNT_W'(1);
            end
          end
          KIND_FINISH: stat_q[STAT_TIMEOUT] <= stat_q[STAT_TIMEOUT] + 64'(busy_cnt_q);
          default: ;
        endcase
      end
      if (cmd_i.stat && matched_q) begin
        stat_q[STAT_RESP] <= stat_q[STAT_RESP] + 64'd1;
        stat_q[STAT_SUM]  <= stat_q[STAT_SUM] + value_q;
        if (value_q < stat_q[STAT_MIN]) stat_q[STAT_MIN] <= value_q;
        if (value_q > stat_q[STAT_MAX]) stat_q[STAT_MAX] <= value_q;
        priority if (rcode_q == RC_OK) begin
          stat_q[STAT_NOERR] <= stat_q[STAT_NOERR] + 64'd1;
        end else if (rcode_q == RC_NAME_ERR) begin
          stat_q[STAT_NXDOM] <= stat_q[STAT_NXDOM] + 64'd1;
        end else if (rcode_q == RC_SRV_FAIL) begin
          stat_q[STAT_SRVF] <= stat_q[STAT_SRVF] + 64'd1;
        end else begin
          stat_q[STAT_OTHER] <= stat_q[STAT_OTHER] + 64'd1;
        end
      end
    end
  end

  // Output register: holds one result until its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_status_q <= status_q;
      out_data_q   <= {stat_q[STAT_OTHER], stat_q[STAT_SRVF], stat_q[STAT_NXDOM],
                       stat_q[STAT_NOERR], stat_q[STAT_MAX], stat_q[STAT_MIN],
                       stat_q[STAT_SUM], stat_q[STAT_RESP], stat_q[STAT_TIMEOUT],
                       value_q, assigned_q};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;

  assign sts_o.clr_done = (clr_cnt_q == CLR_W'(CLR_N - 1));
  assign sts_o.kind     = kind_q;
  assign sts_o.hist_hit = hist_hit;
  assign sts_o.out_busy = out_valid_q;

  // The busy count never exceeds the number of slots.
  a_busy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_cnt_q <= BCNT_W'(ID_SLOTS))
    else $error("busy count above slot count");

  // Once a response has matched, the minimum lies at or below the maximum.
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_q[STAT_RESP] != 64'd0) |-> (stat_q[STAT_MIN] <= stat_q[STAT_MAX]))
    else $error("minimum above maximum");

  // A result is never loaded over one that waits.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> !out_valid_q)
    else $error("result overwritten");

  // A histogram write always follows its read.
  a_hist_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hwr |-> $past(cmd_i.hrd))
    else $error("histogram write without read");

endmodule

// File: sv/dns_query_rtt_tracker_top.sv
// Tracks outstanding DNS queries by 16-bit transaction ID and measures their round-trip
// times. After reset a clearing pass wipes the busy bits and the histogram, during which
// no transfer is accepted. One item is at work at a time: a send, a bucket read or a finish
// passes from acceptance through a read state, for the registered reads of the slot
// memories, and a compute state to the output state; a response, ignored or matched, passes
// also through a statistics state, and a matched response that bumps a histogram bucket
// also through the read-modify-write of that bucket. A new item is accepted while the
// previous result still waits in the output register; the next result is held back until
// that transfer completes.
module dns_query_rtt_tracker_top import dqrt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // kind
  input  logic [KIND_W-1:0]     s_axis_tuser,
  // timestamp_ns, response_id, response_rcode, response_length, bucket_index
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status
  output logic [STS_W-1:0]      m_axis_tuser,
  // assigned_id, value, timeout_total, response_total, rtt_sum, rtt_min, rtt_max,
  // noerror_total, nxdomain_total, servfail_total, other_rcode_total
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  dqrt_cmd_t cmd;
  dqrt_sts_t sts;

  dqrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dqrt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_kind_i    (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_data_o   (m_axis_tdata)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import dqrt_pkg::*;

  // One expected result, laid out field by field.
  typedef struct {
    logic [STS_W-1:0] status;
    logic [15:0]      assigned_id;
    logic [63:0]      value;
    logic [63:0]      stats [STAT_N];
  } rtt_result_t;

  // Predicts the tracker and holds the results still to arrive.
  class rtt_scoreboard;
    logic [63:0] slot_time [int unsigned];
    bit          slot_busy [int unsigned];
    logic [15:0] next_id;
    logic [63:0] busy_count;
    logic [63:0] hist [HIST_BUCKETS];
    logic [63:0] stats [STAT_N];
    rtt_result_t pending [$];
    int          errors;

    function new();
      next_id    = '0;
      busy_count = '0;
      errors     = 0;
      foreach (hist[i]) hist[i] = '0;
      foreach (stats[i]) stats[i] = '0;
      stats[STAT_MIN] = '1;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [63:0] ts, logic [15:0] rid,
                            logic [3:0] rcode, logic [9:0] rlen, logic [9:0] bidx);
      rtt_result_t r;
      logic [63:0] rtt;
      logic [63:0] us;
      r.assigned_id = '0;
      r.value       = '0;
      case (kind)
        KIND_SEND: begin
          if (slot_busy.exists(next_id) && slot_busy[next_id]) begin
            stats[STAT_TIMEOUT]++;
            r.status = STS_EVICT;
          end else begin
            slot_busy[next_id] = 1'b1;
            busy_count++;
            r.status = STS_SENT;
          end
          slot_time[next_id] = ts;
          r.assigned_id = next_id;
          next_id++;
        end
        KIND_RESP: begin
          if (rlen < MIN_LEN || !(slot_busy.exists(rid) && slot_busy[rid])) begin
            r.status = STS_IGNORED;
          end else begin
            rtt = ts - slot_time[rid];
            us  = rtt / 64'd1000;
            slot_busy[rid] = 1'b0;
            busy_count--;
            stats[STAT_RESP]++;
            stats[STAT_SUM] += rtt;
            if (rtt < stats[STAT_MIN]) stats[STAT_MIN] = rtt;
            if (rtt > stats[STAT_MAX]) stats[STAT_MAX] = rtt;
            if (us < HIST_BUCKETS) hist[us]++;
            if (rcode == RC_OK) stats[STAT_NOERR]++;
            else if (rcode == RC_NAME_ERR) stats[STAT_NXDOM]++;
            else if (rcode == RC_SRV_FAIL) stats[STAT_SRVF]++;
            else stats[STAT_OTHER]++;
            r.status = STS_MATCH;
            r.value  = rtt;
          end
        end
        KIND_BUCKET: begin
          if (bidx < HIST_BUCKETS) r.value = hist[bidx];
          r.status = STS_BUCKET;
        end
        default: begin
          stats[STAT_TIMEOUT] += busy_count;
          r.status = STS_FINISH;
        end
      endcase
      r.stats = stats;
      pending.push_back(r);
    endfunction

    function void check_result(logic [STS_W-1:0] sts, logic [OUT_DATA_W-1:0] data);
      rtt_result_t e;
      bit bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d", sts);
        return;
      end
      e   = pending.pop_front();
      bad = (sts !== e.status) || (data[15:0] !== e.assigned_id)
            || (data[79:16] !== e.value);
      for (int i = 0; i < STAT_N; i++)
        if (data[80 + 64*i +: 64] !== e.stats[i]) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp status %0d id %h value %h, got status %0d id %h value %h",
                   e.status, e.assigned_id, e.value, sts, data[15:0], data[79:16]);
          for (int i = 0; i < STAT_N; i++)
            $display("  stat %0d: exp %h got %h", i, e.stats[i], data[80 + 64*i +: 64]);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [KIND_W-1:0]     s_axis_tuser;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [STS_W-1:0]      m_axis_tuser;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  rtt_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_recv;
  int  quiet_cycles;
  logic [63:0] now_ns;

  dns_query_rtt_tracker_top u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stall, with an optional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  // Watchdog on cycles with no transfer at all.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offers one item and waits for its transfer; idle cycles go before it.
  // Valid stays high after a transfer until the next item or an idle cycle replaces it.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [63:0] ts, logic [15:0] rid,
                           logic [3:0] rcode, logic [9:0] rlen, logic [9:0] bidx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {bidx, rlen, rcode, rid, ts};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(kind, ts, rid, rcode, rlen, bidx);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic: queries and answers to recent IDs.
  task automatic random_item();
    int unsigned pick;
    logic [63:0] ts;
    logic [15:0] rid;
    pick = $urandom_range(99);
    now_ns += $urandom_range(3000);
    ts = now_ns;
    if ($urandom_range(19) == 0) ts = {$urandom, $urandom};
    if (pick < 40) begin
      send_item(KIND_SEND, ts, 16'(pick), 4'($urandom), 10'($urandom), 10'($urandom));
    end else if (pick < 85) begin
      rid = sb.next_id - 16'd1 - 16'($urandom_range(7));
      if (pick < 48) rid = 16'($urandom);
      send_item(KIND_RESP, ts, rid, 4'($urandom),
                (pick % 9 == 0) ? 10'($urandom_range(11)) : 10'($urandom_range(12, 1023)),
                10'($urandom));
    end else if (pick < 97) begin
      send_item(KIND_BUCKET, ts, 16'($urandom), 4'($urandom), 10'($urandom),
                (pick & 1) ? 10'($urandom_range(3)) : 10'($urandom));
    end else begin
      send_item(KIND_FINISH, ts, 16'($urandom), 4'($urandom), 10'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = KIND_SEND;
    s_axis_tdata  = '0;
    hold_recv     = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 46;
    now_ns        = 64'd5000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every kind, short and unknown responses, time going backwards.
    send_item(KIND_SEND, 64'd0, '0, '0, '0, '0);
    send_item(KIND_SEND, '1, '1, '1, 10'd512, '1);
    send_item(KIND_SEND, 64'd1000, '0, '0, '0, '0);
    send_item(KIND_RESP, 64'd1500, 16'd0, RC_OK, 10'd11, '0);
    send_item(KIND_RESP, 64'd1500, 16'd0, RC_OK, 10'd12, '0);
    send_item(KIND_RESP, 64'd5, 16'd1, RC_NAME_ERR, 10'd512, '0);
    send_item(KIND_RESP, 64'd2999, 16'd2, RC_SRV_FAIL, '1, '0);
    send_item(KIND_RESP, 64'd2999, 16'd2, 4'd15, '1, '0);
    send_item(KIND_RESP, '1, '1, 4'd1, 10'd100, '0);
    send_item(KIND_SEND, 64'd10, '0, '0, '0, '0);
    send_item(KIND_RESP, 64'd1_023_999 + 64'd10, 16'd3, 4'd1, 10'd12, '0);
    send_item(KIND_SEND, 64'd10, '0, '0, '0, '0);
    send_item(KIND_RESP, 64'd1_024_000 + 64'd10, 16'd4, 4'd5, 10'd12, '0);
    send_item(KIND_SEND, 64'd77, '0, '0, '0, '0);
    send_item(KIND_BUCKET, '0, '0, '0, '0, 10'd0);
    send_item(KIND_BUCKET, '0, '0, '0, '0, 10'd1);
    send_item(KIND_BUCKET, '0, '0, '0, '0, 10'd1023);
    send_item(KIND_BUCKET, '0, '0, '0, '0, 10'd2);
    send_item(KIND_FINISH, '0, '0, '0, '0, '0);
    send_item(KIND_FINISH, '1, '1, '1, '1, '1);

    // Random traffic in three idling phases.
    for (int i = 0; i < 1150; i++) begin
      if (i == 380) begin
        send_idle_pct = 46;
        recv_idle_pct = 34;
      end
      if (i == 760) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Sender pauses until the tracker has caught up.
        drain();
      end
      if (i == 800) hold_recv = 1'b1;
      random_item();
    end
    send_item(KIND_FINISH, '0, '0, '0, '0, '0);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Long receiver hold-off, counted in cycles, while the sender keeps offering.
  initial begin
    wait (hold_recv);
    repeat (300) @(posedge clk_i);
    hold_recv <= 1'b0;
  end

endmodule
